>>> sv/edmf_pkg.sv
// Shared types, codes and constants of the drive-mode state machine.
`default_nettype none
package edmf_pkg;

  localparam int PULSE_W  = 12;
  localparam int OFFSET_W = 11;
  localparam int THRESH_W = 12;
  localparam int ADJ_W    = 14;
  localparam int MODE_W   = 3;
  localparam int ZONE_W   = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET       = 11'sd0;
  localparam logic [THRESH_W-1:0] FORWARD_RESET      = 12'd1440;
  localparam logic [THRESH_W-1:0] REVERSE_RESET      = 12'd1560;
  localparam logic [THRESH_W-1:0] BRAKE_RELEASE_RESET = 12'd1540;

  localparam logic [1:0] REG_OFFSET        = 2'd0;
  localparam logic [1:0] REG_FORWARD_BELOW = 2'd1;
  localparam logic [1:0] REG_REVERSE_ABOVE = 2'd2;
  localparam logic [1:0] REG_BRAKE_RELEASE = 2'd3;

  localparam logic [ZONE_W-1:0] ZONE_NEUTRAL = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_FORWARD = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_REVERSE = 2'd2;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] pulse_offset_us;
    logic [THRESH_W-1:0]        forward_below_us;
    logic [THRESH_W-1:0]        reverse_above_us;
    logic [THRESH_W-1:0]        brake_release_below_us;
  } cfg_t;

  // One classified word passed from front to back.
  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic              release_ok;
  } cls_word_t;

endpackage
`default_nettype wire

>>> sv/esc_drive_mode_fsm.sv
// Top level of the drive-mode state machine: register file, front, queue and back.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               pulse_width_us[11:0]
//  result    out        empty / pop               run_mode[2:0], stick_zone[1:0]
//  config    in/out     psel penable pwrite pready paddr[3:0], pwdata/prdata[31:0]
//
// One word is taken per clock and one result word leaves per clock while the consumer pops;
// the rate is set by the single mode register that the back steps once per word.
// A word is written into the queue when accepted; the machine steps on it when the
// result register is free or popped, and writes the result word into that register.
// Reset loads the register defaults, clears the mode to neutral and empties both the
// queue and the result register; there is no clearing pass.
// A stalled consumer fills the result register, then the two-word queue, then raises full.
`default_nettype none
module esc_drive_mode_fsm #(
  parameter int QUEUE_DEPTH = edmf_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input queue side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [edmf_pkg::PULSE_W-1:0]  pulse_width_us,
  // result queue side
  output logic                               empty,
  input  wire logic                          pop,
  output logic [edmf_pkg::MODE_W-1:0]        run_mode,
  output logic [edmf_pkg::ZONE_W-1:0]        stick_zone,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [edmf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [edmf_pkg::DATA_W-1:0]   pwdata,
  output logic [edmf_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import edmf_pkg::*;

  cfg_t       cfg;
  cls_word_t  front_word;
  cls_word_t  back_word;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       q_empty;
  logic       q_take;

  // Registers are word aligned; drop the byte offset.
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_offset_us        <= OFFSET_RESET;
      cfg.forward_below_us       <= FORWARD_RESET;
      cfg.reverse_above_us       <= REVERSE_RESET;
      cfg.brake_release_below_us <= BRAKE_RELEASE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OFFSET:        cfg.pulse_offset_us        <= pwdata[OFFSET_W-1:0];
        REG_FORWARD_BELOW: cfg.forward_below_us       <= pwdata[THRESH_W-1:0];
        REG_REVERSE_ABOVE: cfg.reverse_above_us       <= pwdata[THRESH_W-1:0];
        REG_BRAKE_RELEASE: cfg.brake_release_below_us <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back: sign-extend the trim, zero-extend the thresholds.
  always_comb begin
    unique case (reg_idx)
      REG_OFFSET: prdata = {{(DATA_W-OFFSET_W){cfg.pulse_offset_us[OFFSET_W-1]}},
                            cfg.pulse_offset_us};
      REG_FORWARD_BELOW: prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg.forward_below_us};
      REG_REVERSE_ABOVE: prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg.reverse_above_us};
      REG_BRAKE_RELEASE: prdata = {{(DATA_W-THRESH_W){1'b0}},
                                   cfg.brake_release_below_us};
      default: prdata = '0;
    endcase
  end

  // Classify on the way in.
  edmf_front u_front (
    .pulse_width_us (pulse_width_us),
    .cfg            (cfg),
    .word           (front_word)
  );

  // Decouple the classifier from the machine; full stalls the producer.
  edmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_word),
    .wr_full  (full),
    .rd_en    (q_take),
    .rd_data  (back_word),
    .rd_empty (q_empty)
  );

  // Step the mode machine and hold the result word until popped.
  edmf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_word    (back_word),
    .in_empty   (q_empty),
    .in_take    (q_take),
    .run_mode   (run_mode),
    .stick_zone (stick_zone),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

>>> sv/edmf_front.sv
// Front end: apply the trim and classify each pulse width into a stick zone.
`default_nettype none
module edmf_front (
  input  wire logic [edmf_pkg::PULSE_W-1:0] pulse_width_us,
  input  wire edmf_pkg::cfg_t               cfg,
  output edmf_pkg::cls_word_t               word
);
  import edmf_pkg::*;

  logic signed [ADJ_W-1:0] adj;
  logic signed [ADJ_W-1:0] fwd_s;
  logic signed [ADJ_W-1:0] rev_s;
  logic signed [ADJ_W-1:0] brk_s;

  assign adj = $signed({{(ADJ_W-PULSE_W){1'b0}}, pulse_width_us})
             + $signed({{(ADJ_W-OFFSET_W){cfg.pulse_offset_us[OFFSET_W-1]}},
                        cfg.pulse_offset_us});
  assign fwd_s = $signed({{(ADJ_W-THRESH_W){1'b0}}, cfg.forward_below_us});
  assign rev_s = $signed({{(ADJ_W-THRESH_W){1'b0}}, cfg.reverse_above_us});
  assign brk_s = $signed({{(ADJ_W-THRESH_W){1'b0}}, cfg.brake_release_below_us});

  // Forward wins where the thresholds overlap.
  always_comb begin
    if (adj < fwd_s) begin
      word.zone = ZONE_FORWARD;
    end else if (adj > rev_s) begin
      word.zone = ZONE_REVERSE;
    end else begin
      word.zone = ZONE_NEUTRAL;
    end
    word.release_ok = (adj < brk_s);
  end

endmodule
`default_nettype wire

>>> sv/edmf_queue.sv
// Short register queue of classified words between front and back.
`default_nettype none
module edmf_queue #(
  parameter int DEPTH = edmf_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire edmf_pkg::cls_word_t wr_data,
  output logic                     wr_full,
  input  wire logic                rd_en,
  output edmf_pkg::cls_word_t      rd_data,
  output logic                     rd_empty
);
  import edmf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_word_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign wr_full  = (count == CNT_W'(DEPTH));
  assign rd_empty = (count == '0);
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && !rd_empty;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on read");
`endif

endmodule
`default_nettype wire

>>> sv/edmf_back.sv
// Back end: step the drive-mode machine and hold the result word for the consumer.
`default_nettype none
module edmf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire edmf_pkg::cls_word_t           in_word,
  input  wire logic                          in_empty,
  output logic                               in_take,
  output logic [edmf_pkg::MODE_W-1:0]        run_mode,
  output logic [edmf_pkg::ZONE_W-1:0]        stick_zone,
  output logic                               empty,
  input  wire logic                          pop
);
  import edmf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NEUTRAL               = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORWARD               = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKWARDS             = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEUTRAL_AFTER_FORWARD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BRAKE                 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BRAKE_REVERSE         = 3'd5;

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic              out_valid;

  assign empty   = !out_valid;
  assign in_take = !in_empty && (!out_valid || pop);

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_NEUTRAL, MODE_BACKWARDS: begin
        if (in_word.zone == ZONE_FORWARD) begin
          mode_next = MODE_FORWARD;
        end else if (in_word.zone == ZONE_REVERSE) begin
          mode_next = MODE_BACKWARDS;
        end else begin
          mode_next = MODE_NEUTRAL;
        end
      end
      MODE_FORWARD: begin
        mode_next = (in_word.zone == ZONE_FORWARD) ? MODE_FORWARD
                                                   : MODE_NEUTRAL_AFTER_FORWARD;
      end
      MODE_NEUTRAL_AFTER_FORWARD: begin
        if (in_word.zone == ZONE_REVERSE) begin
          mode_next = MODE_BRAKE;
        end else if (in_word.zone == ZONE_FORWARD) begin
          mode_next = MODE_FORWARD;
        end
      end
      MODE_BRAKE: begin
        if (in_word.zone == ZONE_FORWARD) begin
          mode_next = MODE_FORWARD;
        end else if (in_word.zone == ZONE_REVERSE) begin
          mode_next = MODE_BRAKE_REVERSE;
        end else if (in_word.release_ok) begin
          mode_next = MODE_NEUTRAL;
        end
      end
      MODE_BRAKE_REVERSE: begin
        if (in_word.zone == ZONE_FORWARD) begin
          mode_next = MODE_FORWARD;
        end else if (in_word.zone != ZONE_REVERSE) begin
          mode_next = MODE_NEUTRAL;
        end
      end
      default: mode_next = mode;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NEUTRAL;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        mode      <= mode_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      run_mode   <= mode_next;
      stick_zone <= in_word.zone;
    end
  end

`ifndef SYNTHESIS
  a_fwd_wins: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_word.zone == ZONE_FORWARD) |=> (mode == MODE_FORWARD))
    else $error("forward zone did not select forward mode");
  a_out_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    $past(in_take) |-> (run_mode == mode))
    else $error("result word does not match mode register");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(run_mode) && $stable(stick_zone)))
    else $error("waiting result word changed before it was popped");
`endif

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the drive-mode machine: directed walks, random pulses, stalls.
module tb_top;
  import edmf_pkg::*;

  // Drive modes as the result port codes them.
  typedef enum logic [MODE_W-1:0] {
    DM_NEUTRAL           = 3'd0,
    DM_FORWARD           = 3'd1,
    DM_BACKWARDS         = 3'd2,
    DM_NEUTRAL_AFTER_FWD = 3'd3,
    DM_BRAKE             = 3'd4,
    DM_BRAKE_REVERSE     = 3'd5
  } run_mode_e;

  // One result word as the block should deliver it.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ZONE_W-1:0] zone;
  } mode_word_t;

  localparam int CYCLE_LIMIT = 100000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [PULSE_W-1:0]  pulse_width_us = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [MODE_W-1:0]   run_mode;
  logic [ZONE_W-1:0]   stick_zone;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Our own copy of the register file and of the mode register.
  logic signed [OFFSET_W-1:0] trim_us = OFFSET_RESET;
  logic [THRESH_W-1:0]        fwd_below = FORWARD_RESET;
  logic [THRESH_W-1:0]        rev_above = REVERSE_RESET;
  logic [THRESH_W-1:0]        brake_release = BRAKE_RELEASE_RESET;
  run_mode_e                  mode_now = DM_NEUTRAL;

  mode_word_t mode_words_due[$];
  int         errors = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       holding = 1'b0;
  int         hold_len = 0;
  event       hold_go;

  esc_drive_mode_fsm u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pulse_width_us (pulse_width_us),
    .empty          (empty),
    .pop            (pop),
    .run_mode       (run_mode),
    .stick_zone     (stick_zone),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Classify one accepted pulse and step our copy of the machine; queue the word it yields.
  function automatic void predict_step(input logic [PULSE_W-1:0] width);
    int                adj;
    logic [ZONE_W-1:0] zone;
    mode_word_t        word;
    adj  = int'(width) + int'(trim_us);
    zone = ZONE_NEUTRAL;
    // Forward wins where the thresholds overlap.
    if (adj < int'(fwd_below)) zone = ZONE_FORWARD;
    else if (adj > int'(rev_above)) zone = ZONE_REVERSE;
    case (mode_now)
      DM_NEUTRAL, DM_BACKWARDS: begin
        if (zone == ZONE_FORWARD) mode_now = DM_FORWARD;
        else if (zone == ZONE_REVERSE) mode_now = DM_BACKWARDS;
        else mode_now = DM_NEUTRAL;
      end
      DM_FORWARD: begin
        mode_now = (zone == ZONE_FORWARD) ? DM_FORWARD : DM_NEUTRAL_AFTER_FWD;
      end
      DM_NEUTRAL_AFTER_FWD: begin
        if (zone == ZONE_REVERSE) mode_now = DM_BRAKE;
        else if (zone == ZONE_FORWARD) mode_now = DM_FORWARD;
      end
      DM_BRAKE: begin
        // Release the brake only well inside the neutral band.
        if (zone == ZONE_NEUTRAL) begin
          if (adj < int'(brake_release)) mode_now = DM_NEUTRAL;
        end else if (zone == ZONE_FORWARD) begin
          mode_now = DM_FORWARD;
        end else begin
          mode_now = DM_BRAKE_REVERSE;
        end
      end
      DM_BRAKE_REVERSE: begin
        if (zone == ZONE_NEUTRAL) mode_now = DM_NEUTRAL;
        else if (zone == ZONE_FORWARD) mode_now = DM_FORWARD;
      end
      default: ;
    endcase
    word.mode = mode_now;
    word.zone = zone;
    mode_words_due.push_back(word);
  endfunction

  // Receiver: idle at random, or hold right off while a long stall is running.
  always @(negedge clk) begin
    pop <= !holding && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver stall, counted here in whole cycles.
  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (hold_len) @(posedge clk);
      holding = 1'b0;
    end
  end

  // Compare every word taken from the block against the oldest one due.
  always @(posedge clk) begin
    mode_word_t want;
    if (!rst && pop && !empty) begin
      if (mode_words_due.size() == 0) begin
        $display("%0t: result with none due: mode %0d zone %0d", $time, run_mode, stick_zone);
        errors++;
      end else begin
        want = mode_words_due.pop_front();
        if (want.mode !== run_mode) begin
          $display("%0t: run_mode expected %0d actual %0d", $time, want.mode, run_mode);
          errors++;
        end
        if (want.zone !== stick_zone) begin
          $display("%0t: stick_zone expected %0d actual %0d", $time, want.zone, stick_zone);
          errors++;
        end
      end
    end
  end

  // Offer one pulse word, idling first at random; predict once it is taken.
  task automatic send_pulse(input logic [PULSE_W-1:0] width);
    @(negedge clk);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    pulse_width_us <= width;
    do @(posedge clk); while (full);
    predict_step(width);
  endtask

  task automatic stop_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // Wait for every word due, then let the pipe settle.
  task automatic wait_drained();
    while (mode_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back over the same select.
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [THRESH_W-1:0] got;
    logic [THRESH_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_OFFSET:        trim_us = value[OFFSET_W-1:0];
      REG_FORWARD_BELOW: fwd_below = value[THRESH_W-1:0];
      REG_REVERSE_ABOVE: rev_above = value[THRESH_W-1:0];
      REG_BRAKE_RELEASE: brake_release = value[THRESH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Compare only the bits the register holds.
    if (idx == REG_OFFSET) begin
      got  = {1'b0, prdata[OFFSET_W-1:0]};
      want = {1'b0, value[OFFSET_W-1:0]};
    end else begin
      got  = prdata[THRESH_W-1:0];
      want = value[THRESH_W-1:0];
    end
    if (got !== want) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, want, got);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_all(input int offset, input int fwd, input int rev, input int brk);
    cfg_write(REG_OFFSET, DATA_W'(offset));
    cfg_write(REG_FORWARD_BELOW, DATA_W'(fwd));
    cfg_write(REG_REVERSE_ABOVE, DATA_W'(rev));
    cfg_write(REG_BRAKE_RELEASE, DATA_W'(brk));
  endtask

  // Aim mostly at the thresholds of the current setting so every mode is reached.
  function automatic logic [PULSE_W-1:0] pick_pulse();
    int target;
    int w;
    target = 0;
    case ($urandom_range(7))
      0: return PULSE_W'($urandom_range(4095));
      1: target = int'(fwd_below) + int'($urandom_range(80)) - 40;
      2: target = int'(rev_above) + int'($urandom_range(80)) - 40;
      3: target = int'(brake_release) + int'($urandom_range(80)) - 40;
      4: target = int'($urandom_range(int'(fwd_below))) - 20;
      5: target = int'(rev_above) + int'($urandom_range(600));
      default: begin
        if (rev_above > fwd_below)
          target = int'(fwd_below) + int'($urandom_range(int'(rev_above - fwd_below)));
        else
          target = int'(fwd_below);
      end
    endcase
    w = target - int'(trim_us);
    if (w < 0) w = 0;
    if (w > 4095) w = 4095;
    return PULSE_W'(w);
  endfunction

  // Walk the machine through every mode at the default setting.
  task automatic test_mode_walk();
    int walk[$];
    walk = '{0, 4095, 1500, 1000, 1500, 2000, 1550, 1539, 2000, 2000, 1500,
             1000, 2000, 2000, 1561, 4095, 1500, 1000, 1440, 1560, 1000,
             1439, 1500, 1561, 1000};
    foreach (walk[i]) send_pulse(PULSE_W'(walk[i]));
    stop_push();
    wait_drained();
  endtask

  // Adjusted width at both ends of its range, and overlapping thresholds.
  task automatic test_threshold_corners();
    set_all(-1024, 1440, 1560, 1540);
    send_pulse(0);
    send_pulse(4095);
    send_pulse(1000);
    stop_push();
    wait_drained();
    set_all(1023, 4095, 4095, 4095);
    send_pulse(4095);
    send_pulse(0);
    stop_push();
    wait_drained();
    cfg_write(REG_FORWARD_BELOW, 3000);
    cfg_write(REG_REVERSE_ABOVE, 1000);
    cfg_write(REG_OFFSET, 0);
    send_pulse(2000);
    send_pulse(2999);
    send_pulse(3000);
    send_pulse(500);
    stop_push();
    wait_drained();
    set_all(0, 0, 0, 0);
    send_pulse(0);
    send_pulse(1);
    send_pulse(4095);
    stop_push();
    wait_drained();
  endtask

  // Random pulses over a run of settings and idling patterns.
  task automatic test_random_phases();
    for (int phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 52;
      end else if (phase < 6) begin
        tx_idle_pct = 52;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase % 3)
        0: set_all(int'($urandom_range(200)) - 100, 1300 + int'($urandom_range(150)),
                   1580 + int'($urandom_range(150)), 1450 + int'($urandom_range(120)));
        1: set_all(int'($urandom_range(2047)), int'($urandom_range(4095)),
                   int'($urandom_range(4095)), int'($urandom_range(4095)));
        default: begin
          case ($urandom_range(3))
            0: set_all(-1024, 0, 0, 0);
            1: set_all(1023, 4095, 4095, 4095);
            2: set_all(-1000, 1440, 1560, 1540);
            default: set_all(1000, 1440, 1560, 1540);
          endcase
        end
      endcase
      for (int n = 0; n < 78; n++) begin
        // Pause the sender once until the block has delivered every word due.
        if (phase == 0 && n == 39) begin
          stop_push();
          wait_drained();
        end
        send_pulse(pick_pulse());
      end
      stop_push();
      wait_drained();
    end
  endtask

  // Stall the receiver for a long stretch while words keep coming, so full rises.
  task automatic test_backpressure();
    set_all(0, 1440, 1560, 1540);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len    = 300;
    @(posedge clk);
    -> hold_go;
    for (int n = 0; n < 40; n++) send_pulse(pick_pulse());
    stop_push();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_mode_walk();
    test_threshold_corners();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && mode_words_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
